>>> sv/ribt_pkg.sv
`default_nettype none

package ribt_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned DurationW = 11;
  localparam int unsigned LcgW      = 32;
  localparam int unsigned ElapsedW  = 14;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [LcgW-1:0] LcgMul    = 32'd1664525;
  localparam logic [LcgW-1:0] LcgAdd    = 32'd1013904223;
  localparam logic [LcgW-1:0] SeedSubst = 32'h9E37_79B9;

  localparam logic [ElapsedW-1:0]  ElapsedCap = 14'd10000;
  localparam logic [IntervalW-1:0] IntervalLo = 16'd250;
  localparam logic [IntervalW-1:0] IntervalHi = 16'd60000;
  localparam logic [DurationW-1:0] DurationLo = 11'd40;
  localparam logic [DurationW-1:0] DurationHi = 11'd2000;

  localparam logic [IntervalW-1:0] MinReset   = 16'd3500;
  localparam logic [IntervalW-1:0] MaxReset   = 16'd6500;
  localparam logic [DurationW-1:0] BlinkReset = 11'd120;

  localparam logic [CfgIdxW-1:0] RegMin   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMax   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlink = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSeed  = 2'd3;

  typedef struct packed {
    logic cfg_we;
    logic in_load;
    logic lcg_mul;
    logic lcg_add;
    logic scale;
    logic load_draw;
    logic flip;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic boundary;
    logic in_blink;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/ribt_ctrl.sv
`default_nettype none

module ribt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ribt_pkg::sts_t sts_i,
  output ribt_pkg::cmd_t     cmd_o
);
  import ribt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StAdd   = 3'd2;
  localparam logic [2:0] StScale = 3'd3;
  localparam logic [2:0] StLoad  = 3'd4;
  localparam logic [2:0] StStep  = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ret_step_q, ret_step_d;

  assign cfg_ready_o = (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle) | cfg_valid_i;

  always_comb begin
    state_d    = state_q;
    ret_step_d = ret_step_q;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
          ret_step_d   = 1'b0;
          state_d      = StMul;
        end else if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = StStep;
        end
      end
      StMul: begin
        cmd_o.lcg_mul = 1'b1;
        state_d       = StAdd;
      end
      StAdd: begin
        cmd_o.lcg_add = 1'b1;
        state_d       = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StLoad;
      end
      StLoad: begin
        cmd_o.load_draw = 1'b1;
        state_d         = ret_step_q ? StStep : StIdle;
      end
      StStep: begin
        if (sts_i.boundary) begin
          cmd_o.flip = 1'b1;
          if (sts_i.in_blink) begin
            ret_step_d = 1'b1;
            state_d    = StMul;
          end
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = StDone;
        end
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // first interval is drawn right after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StMul;
      ret_step_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_step_q <= ret_step_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cfg_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cfg_we |=> state_q == StMul && !ret_step_q)
    else $error("config write did not start a draw");
  a_no_dual_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.cfg_we && cmd_o.in_load))
    else $error("config and input accepted together");
  a_load_returns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_draw && ret_step_q |=> state_q == StStep)
    else $error("draw inside a step did not return to stepping");
`endif

endmodule

`default_nettype wire

>>> sv/ribt_dp.sv
`default_nettype none

module ribt_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ribt_pkg::cmd_t                cmd_i,
  output ribt_pkg::sts_t                     sts_o,
  input  wire logic [ribt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ribt_pkg::LcgW-1:0]     cfg_data_i,
  input  wire logic [15:0]                   elapsed_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               blinking_o,
  output logic [ribt_pkg::IntervalW-1:0]     remaining_ms_o,
  output logic                               toggled_o
);
  import ribt_pkg::*;

  logic [IntervalW-1:0] min_q, min_d, max_q, max_d;
  logic [DurationW-1:0] blink_q, blink_d;
  logic [LcgW-1:0]      lcg_q, prod_q;
  logic [IntervalW-1:0] scaled_q, phase_left_q;
  logic [ElapsedW-1:0]  elapsed_q;
  logic                 in_blink_q, flipped_q, out_valid_q;

  logic [IntervalW-1:0]         wr_iv;
  logic [DurationW-1:0]         wr_dur;
  logic [IntervalW-1:0]         span;
  logic [IntervalW+LcgW-9:0]    scale_prod;
  logic                         boundary;

  always_comb begin
    wr_iv = cfg_data_i[IntervalW-1:0];
    if (wr_iv < IntervalLo) wr_iv = IntervalLo;
    if (wr_iv > IntervalHi) wr_iv = IntervalHi;
    wr_dur = cfg_data_i[DurationW-1:0];
    if (wr_dur < DurationLo) wr_dur = DurationLo;
    if (wr_dur > DurationHi) wr_dur = DurationHi;
  end

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    blink_d = blink_q;
    unique case (cfg_index_i)
      RegMin: begin
        min_d = wr_iv;
        max_d = (max_q < wr_iv) ? wr_iv : max_q;
      end
      RegMax:   max_d = (wr_iv < min_q) ? min_q : wr_iv;
      RegBlink: blink_d = wr_dur;
      RegSeed:  ;
      default:  ;
    endcase
  end

  assign span       = max_q - min_q;
  assign scale_prod = span * lcg_q[LcgW-1:8];
  assign boundary   = {{(IntervalW-ElapsedW){1'b0}}, elapsed_q} >= phase_left_q;

  assign sts_o.boundary = boundary;
  assign sts_o.in_blink = in_blink_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= MinReset;
      max_q       <= MaxReset;
      blink_q     <= BlinkReset;
      lcg_q       <= SeedSubst;
      in_blink_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        min_q      <= min_d;
        max_q      <= max_d;
        blink_q    <= blink_d;
        in_blink_q <= 1'b0;
        if (cfg_index_i == RegSeed) begin
          lcg_q <= (cfg_data_i == '0) ? SeedSubst : cfg_data_i;
        end
      end
      if (cmd_i.lcg_add) lcg_q <= prod_q + LcgAdd;
      if (cmd_i.flip) in_blink_q <= !in_blink_q;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lcg_mul) prod_q <= lcg_q * LcgMul;
    if (cmd_i.scale) scaled_q <= scale_prod[IntervalW+LcgW-9 -: IntervalW];
    if (cmd_i.load_draw) phase_left_q <= min_q + scaled_q;
    if (cmd_i.in_load) begin
      elapsed_q <= (elapsed_ms_i > {{(16-ElapsedW){1'b0}}, ElapsedCap})
                   ? ElapsedCap : elapsed_ms_i[ElapsedW-1:0];
      flipped_q <= 1'b0;
    end
    if (cmd_i.flip) begin
      elapsed_q <= elapsed_q - phase_left_q[ElapsedW-1:0];
      flipped_q <= 1'b1;
      if (!in_blink_q) phase_left_q <= {{(IntervalW-DurationW){1'b0}}, blink_q};
    end
    if (cmd_i.finish) begin
      phase_left_q <= phase_left_q - {{(IntervalW-ElapsedW){1'b0}}, elapsed_q};
    end
    if (cmd_i.out_load) begin
      blinking_o     <= in_blink_q;
      remaining_ms_o <= phase_left_q;
      toggled_o      <= flipped_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni) max_q >= min_q)
    else $error("maximum interval below minimum");
  a_cross_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flip |-> phase_left_q != '0)
    else $error("crossing a zero-length phase");
  a_draw_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_draw |=> phase_left_q >= min_q && phase_left_q <= max_q)
    else $error("drawn interval out of range");
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q || !out_stall_i)
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

>>> sv/random_interval_blink_timer.sv
`default_nettype none

// Two-phase blink timer: an open phase of random length between the minimum
// and maximum interval, then a blink phase of fixed length. Each input beat
// carries elapsed milliseconds and yields one result beat. An accepted beat
// passes through a step state once for each phase crossing and once more to
// finish, then waits in a done state until its result beat can be loaded,
// before the next beat can be taken. Each crossing back to the open phase
// draws a new interval: the generator multiply, add and scaling multiply run
// one after another on the datapath. A stalled result beat holds the block
// in its done state. After reset and after any register write the block
// draws the first interval before it takes the next beat.
module random_interval_blink_timer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ribt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ribt_pkg::LcgW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [15:0]                   elapsed_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               blinking_o,
  output logic [15:0]                        remaining_ms_o,
  output logic                               toggled_o
);
  import ribt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ribt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ribt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blinking_o     (blinking_o),
    .remaining_ms_o (remaining_ms_o),
    .toggled_o      (toggled_o)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ribt_pkg::*;

  localparam realtime HalfPeriod = 1.0;
  localparam int ResetCycles = 9;
  localparam int RandomItems = 1000;
  localparam int MaxGap = 17;
  localparam int SettleCycles = 20;
  localparam int QuietLimit = 5000;
  localparam int ReportLimit = 10;
  localparam int PlanLen = 35;
  localparam bit CfgRow = 1'b1;
  localparam bit ItemRow = 1'b0;

  typedef struct packed {
    logic        blinking;
    logic [15:0] remaining;
    logic        toggled;
  } blink_result_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        value;
    bit                 pinned;
    blink_result_t      want;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [LcgW-1:0]      cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [15:0]          elapsed_ms_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 blinking_o;
  logic [15:0]          remaining_ms_o;
  logic                 toggled_o;

  random_interval_blink_timer dut (.*);

  always #HalfPeriod clk_i = ~clk_i;

  // timer model state
  logic [IntervalW-1:0] open_min;
  logic [IntervalW-1:0] open_max;
  logic [DurationW-1:0] blink_len;
  logic [LcgW-1:0]      lcg_word;
  logic                 in_blink_now;
  logic [15:0]          phase_left_ms;

  blink_result_t pending[$];
  bit            pin_active = 1'b0;
  blink_result_t pin_result = '0;
  bit            calm = 1'b0;
  int            mismatches = 0;
  int            quiet_cycles = 0;

  // min = max = 250, blink 40 gives fixed 290 ms cycles; later rows pin
  // the upper clamps, max raised to min, and a reseed with zero
  plan_row_t plan [PlanLen] = '{
    '{CfgRow,  RegMin,   32'd0,          1'b0, '0},
    '{CfgRow,  RegMax,   32'd0,          1'b0, '0},
    '{CfgRow,  RegBlink, 32'd0,          1'b0, '0},
    '{ItemRow, '0,       32'd0,          1'b1, '{1'b0, 16'd250, 1'b0}},
    '{ItemRow, '0,       32'd100,        1'b1, '{1'b0, 16'd150, 1'b0}},
    '{ItemRow, '0,       32'd150,        1'b1, '{1'b1, 16'd40, 1'b1}},
    '{ItemRow, '0,       32'd20,         1'b1, '{1'b1, 16'd20, 1'b0}},
    '{ItemRow, '0,       32'd20,         1'b1, '{1'b0, 16'd250, 1'b1}},
    '{ItemRow, '0,       32'd65535,      1'b1, '{1'b0, 16'd110, 1'b1}},
    '{ItemRow, '0,       32'd10001,      1'b0, '0},
    '{ItemRow, '0,       32'd1,          1'b0, '0},
    '{CfgRow,  RegMax,   32'hFFFF_FFFF,  1'b0, '0},
    '{CfgRow,  RegMin,   32'hFFFF_FFFF,  1'b0, '0},
    '{CfgRow,  RegBlink, 32'hFFFF_FFFF,  1'b0, '0},
    '{ItemRow, '0,       32'd0,          1'b1, '{1'b0, 16'd60000, 1'b0}},
    '{ItemRow, '0,       32'd10000,      1'b1, '{1'b0, 16'd50000, 1'b0}},
    '{ItemRow, '0,       32'd65535,      1'b1, '{1'b0, 16'd40000, 1'b0}},
    '{ItemRow, '0,       32'd39999,      1'b1, '{1'b0, 16'd30000, 1'b0}},
    '{CfgRow,  RegMin,   32'd5000,       1'b0, '0},
    '{CfgRow,  RegMax,   32'd1000,       1'b0, '0},
    '{ItemRow, '0,       32'd0,          1'b1, '{1'b0, 16'd5000, 1'b0}},
    '{ItemRow, '0,       32'd4999,       1'b1, '{1'b0, 16'd1, 1'b0}},
    '{ItemRow, '0,       32'd1,          1'b1, '{1'b1, 16'd2000, 1'b1}},
    '{ItemRow, '0,       32'd2000,       1'b1, '{1'b0, 16'd5000, 1'b1}},
    '{CfgRow,  RegSeed,  32'd0,          1'b0, '0},
    '{ItemRow, '0,       32'd4,          1'b1, '{1'b0, 16'd4996, 1'b0}},
    '{CfgRow,  RegMin,   32'd250,        1'b0, '0},
    '{ItemRow, '0,       32'd1,          1'b0, '0},
    '{ItemRow, '0,       32'd65535,      1'b0, '0},
    '{CfgRow,  RegSeed,  32'hFFFF_FFFF,  1'b0, '0},
    '{ItemRow, '0,       32'd7,          1'b0, '0},
    '{CfgRow,  RegSeed,  32'h1234_5678,  1'b0, '0},
    '{CfgRow,  RegBlink, 32'h0000_0123,  1'b0, '0},
    '{ItemRow, '0,       32'd3000,       1'b0, '0},
    '{ItemRow, '0,       32'd9999,       1'b0, '0}
  };

  function automatic logic [IntervalW-1:0] draw_open_ms();
    logic [31:0] span;
    logic [63:0] scaled;
    lcg_word = lcg_word * LcgMul + LcgAdd;
    span = 32'(open_max) - 32'(open_min);
    scaled = (64'(span) * 64'(lcg_word >> 8)) >> 24;
    return open_min + scaled[IntervalW-1:0];
  endfunction

  function automatic logic [IntervalW-1:0] clamp_interval(logic [IntervalW-1:0] v);
    if (v < IntervalLo) return IntervalLo;
    if (v > IntervalHi) return IntervalHi;
    return v;
  endfunction

  function automatic void restart_open();
    in_blink_now = 1'b0;
    phase_left_ms = draw_open_ms();
  endfunction

  function automatic void reset_timer_model();
    open_min = MinReset;
    open_max = MaxReset;
    blink_len = BlinkReset;
    lcg_word = SeedSubst;
    restart_open();
  endfunction

  function automatic void write_timer_reg(logic [CfgIdxW-1:0] idx, logic [LcgW-1:0] data);
    logic [DurationW-1:0] dur;
    case (idx)
      RegMin: open_min = clamp_interval(data[IntervalW-1:0]);
      RegMax: open_max = clamp_interval(data[IntervalW-1:0]);
      RegBlink: begin
        dur = data[DurationW-1:0];
        blink_len = (dur < DurationLo) ? DurationLo : (dur > DurationHi) ? DurationHi : dur;
      end
      RegSeed: begin
        lcg_word = (data == '0) ? SeedSubst : data;
      end
      default: return;
    endcase
    if (open_max < open_min) open_max = open_min;
    restart_open();
  endfunction

  function automatic blink_result_t advance_timer(logic [15:0] ms);
    int unsigned left;
    logic flipped;
    left = 32'(ms);
    flipped = 1'b0;
    if (left != 0) begin
      if (left > 32'(ElapsedCap)) left = 32'(ElapsedCap);
      while (left >= 32'(phase_left_ms)) begin
        left -= 32'(phase_left_ms);
        in_blink_now = ~in_blink_now;
        flipped = 1'b1;
        phase_left_ms = in_blink_now ? 16'(blink_len) : draw_open_ms();
      end
      phase_left_ms = phase_left_ms - 16'(left);
    end
    return '{in_blink_now, phase_left_ms, flipped};
  endfunction

  task automatic send_elapsed(input logic [15:0] ms, input bit aim, input bit pin,
                              input blink_result_t pin_val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_ms_i <= aim ? phase_left_ms : ms;
    pin_active <= pin;
    pin_result <= pin_val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LcgW-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : scoreboard
    blink_result_t seen;
    blink_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) write_timer_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        want = advance_timer(elapsed_ms_i);
        pending.push_back(pin_active ? pin_result : want);
      end
      if (out_valid_o && !out_stall_i) begin
        seen = '{blinking_o, remaining_ms_o, toggled_o};
        if (pending.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected result beat: blinking=%0d remaining=%0d toggled=%0d",
                     seen.blinking, seen.remaining, seen.toggled);
        end else begin
          want = pending.pop_front();
          if (seen.blinking !== want.blinking || seen.remaining !== want.remaining ||
              seen.toggled !== want.toggled) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("mismatch: exp blinking=%0d remaining=%0d toggled=%0d, %s%0d %s%0d %s%0d",
                       want.blinking, want.remaining, want.toggled,
                       "got blinking=", seen.blinking, "remaining=", seen.remaining,
                       "toggled=", seen.toggled);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("FAIL random_interval_blink_timer");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, MaxGap);
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : stimulus
    int sent;
    int batch;
    logic [15:0] ms;
    logic [CfgIdxW-1:0] idx;
    logic [LcgW-1:0] data;
    bit aim;
    reset_timer_model();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PlanLen; i++) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].value);
      else send_elapsed(plan[i].value[15:0], 1'b0, plan[i].pinned, plan[i].want);
    end

    sent = 0;
    while (sent < RandomItems) begin
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        idx = CfgIdxW'($urandom_range(0, 3));
        case ($urandom_range(0, 6))
          0: data = '0;
          1: data = '1;
          2: data = $urandom;
          3: data = $urandom_range(250, 1200);
          4: data = $urandom_range(250, 60000);
          5: data = $urandom_range(0, 2100);
          default: data = $urandom_range(30, 300);
        endcase
        write_reg(idx, data);
      end
      batch = $urandom_range(20, 80);
      repeat (batch) begin
        aim = 1'b0;
        case ($urandom_range(0, 9))
          0: ms = '0;
          1: ms = 16'($urandom);
          2: ms = 16'($urandom_range(9990, 10010));
          3: ms = 16'hFFFF;
          4, 5, 6: ms = 16'($urandom_range(1, 40));
          7: ms = 16'($urandom_range(1, 1000));
          default: begin
            ms = '0;
            aim = 1'b1;
          end
        endcase
        if ($urandom_range(0, 59) == 0) drain_results();
        send_elapsed(ms, aim, 1'b0, '0);
        sent++;
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("PASS random_interval_blink_timer");
    end else begin
      $display("FAIL random_interval_blink_timer");
    end
    $finish;
  end

endmodule

`default_nettype wire
